// ===== design/mm64b_pkg.sv =====
// Shared types and constants for the MurmurHash64B byte-stream hasher.
// No dependencies; imported by every module under design/.
`timescale 1ns / 1ps

package mm64b_pkg;

   // Mixing multiplier and word-mix shift
   localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT = 24;

   // Finalization shifts, in round order
   localparam int unsigned FIN_SHIFT_A = 18;
   localparam int unsigned FIN_SHIFT_B = 22;
   localparam int unsigned FIN_SHIFT_C = 17;
   localparam int unsigned FIN_SHIFT_D = 19;

   // Register file: one 32-bit register at byte address 0
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        CSR_IDX_SEED = 1'b0;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_present;
      logic [30:0] key_length;
      logic        last_item;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] hash_wide;
      logic [31:0] hash_narrow;
   } rsp_payload_type;

endpackage

// ===== design/mm64b_mul.sv =====
// Shared multiply unit: operand times the mixing constant, low 32 bits, registered.
// Depends on mm64b_pkg.
`timescale 1ns / 1ps

module mm64b_mul (
   input  logic        clock,
   input  logic [31:0] operand,
   output logic [31:0] product
);
   import mm64b_pkg::*;

   logic [31:0] product_ff;
   logic [31:0] product_in;

   assign product_in = operand * MIX_MUL;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== design/murmur2_64b_string_hash_core.sv =====
// Top level of the MurmurHash64B byte-stream hasher: sequencer, lanes, CSR, output register.
// Depends on mm64b_pkg and mm64b_mul.
`timescale 1ns / 1ps

// Usage
//   req_*  : one key byte per transfer (valid/stall). The first transfer of a key
//            samples key_length and the hash_seed register; last_item closes the key.
//            A transfer with byte_present low and last_item high on a fresh key
//            hashes the empty key.
//   rsp_*  : one transfer per key, carrying the 64-bit hash and the 32-bit fold.
//   csr_*  : APB-style port, hash_seed at byte address 0; pready is tied high.
//            Write the seed only while the block is idle.
// Timing
//   A byte that does not complete a word leaves the sequencer idle. A byte that
//   completes a 32-bit word goes three times through the single registered
//   multiplier (two mix passes, one lane multiply), then the lane is written
//   back. The last item adds finalization (plus a tail pass with 1-3 leftover
//   bytes), again on the shared multiplier, one pass per round.
//   req_stall is high while the sequencer is busy.
// Reset: synchronous, active high: sequencer idle, no key open, seed 0, no result.
// Back-pressure
//   The result sits in an output register; the next key is accepted while it
//   waits. If a new result is ready while the old one is still stalled, the
//   sequencer holds in its output state until the register frees up.

module murmur2_64b_string_hash_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mm64b_pkg::req_payload_type   req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mm64b_pkg::rsp_payload_type   rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import mm64b_pkg::*;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_W1    = 4'd1;   // mul(word)
   localparam logic [3:0] ST_W2    = 4'd2;   // mul(p ^ p>>24)
   localparam logic [3:0] ST_W3    = 4'd3;   // keep k, mul(lane)
   localparam logic [3:0] ST_W4    = 4'd4;   // lane = p ^ k
   localparam logic [3:0] ST_FSTART = 4'd5;  // tail check
   localparam logic [3:0] ST_TAILW = 4'd6;   // lane two = p
   localparam logic [3:0] ST_R1    = 4'd7;
   localparam logic [3:0] ST_R2    = 4'd8;
   localparam logic [3:0] ST_R3    = 4'd9;
   localparam logic [3:0] ST_R4    = 4'd10;
   localparam logic [3:0] ST_R5    = 4'd11;
   localparam logic [3:0] ST_FOUT  = 4'd12;  // load output register

   logic [3:0]      state_ff, state_in;
   logic [31:0]     seed_ff, seed_in;
   logic [31:0]     lane1_ff, lane1_in;
   logic [31:0]     lane2_ff, lane2_in;
   logic [23:0]     partial_ff, partial_in;
   logic [1:0]      slot_ff, slot_in;
   logic            nws_ff, nws_in;       // next word goes to lane two
   logic            inside_ff, inside_in; // key open
   logic            last_ff, last_in;
   logic [31:0]     word_ff, word_in;
   logic [31:0]     k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_acc;
   logic            csr_wr;
   logic            out_free;
   logic [23:0]     eff_partial;
   logic [1:0]      eff_slot;
   logic [31:0]     mul_op;
   logic [31:0]     mul_p;

   mm64b_mul u_mul (
      .clock   (clock),
      .operand (mul_op),
      .product (mul_p)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // CSR: single register, lower address bits ignored
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SEED) ? seed_ff : 32'd0;
   assign seed_in    = (csr_wr && csr_paddr[2] == CSR_IDX_SEED) ? csr_pwdata : seed_ff;

   // a fresh key starts from cleared packing state
   assign eff_partial = inside_ff ? partial_ff : 24'd0;
   assign eff_slot    = inside_ff ? slot_ff : 2'd0;

   always_comb begin
      state_in     = state_ff;
      lane1_in     = lane1_ff;
      lane2_in     = lane2_ff;
      partial_in   = partial_ff;
      slot_in      = slot_ff;
      nws_in       = nws_ff;
      inside_in    = inside_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_op       = 32'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               inside_in = 1'b1;
               last_in   = req_data.last_item;
               if (!inside_ff) begin
                  lane1_in   = seed_ff ^ {1'b0, req_data.key_length};
                  lane2_in   = 32'd0;
                  partial_in = 24'd0;
                  slot_in    = 2'd0;
                  nws_in     = 1'b0;
               end
               if (req_data.byte_present && eff_slot == 2'd3) begin
                  word_in  = {req_data.data_byte, eff_partial};
                  state_in = ST_W1;
               end else begin
                  if (req_data.byte_present) begin
                     partial_in = eff_partial |
                                  ({16'd0, req_data.data_byte} << {eff_slot, 3'b000});
                     slot_in    = eff_slot + 2'd1;
                  end
                  if (req_data.last_item) begin
                     state_in = ST_FSTART;
                  end
               end
            end
         end
         ST_W1: begin
            mul_op   = word_ff;
            state_in = ST_W2;
         end
         ST_W2: begin
            mul_op   = mul_p ^ (mul_p >> MIX_SHIFT);
            state_in = ST_W3;
         end
         ST_W3: begin
            k_in     = mul_p;
            mul_op   = nws_ff ? lane2_ff : lane1_ff;
            state_in = ST_W4;
         end
         ST_W4: begin
            if (nws_ff) begin
               lane2_in = mul_p ^ k_ff;
            end else begin
               lane1_in = mul_p ^ k_ff;
            end
            nws_in     = !nws_ff;
            partial_in = 24'd0;
            slot_in    = 2'd0;
            state_in   = last_ff ? ST_FSTART : ST_IDLE;
         end
         ST_FSTART: begin
            if (slot_ff != 2'd0) begin
               mul_op   = lane2_ff ^ {8'd0, partial_ff};
               state_in = ST_TAILW;
            end else begin
               state_in = ST_R1;
            end
         end
         ST_TAILW: begin
            lane2_in = mul_p;
            state_in = ST_R1;
         end
         ST_R1: begin
            mul_op   = lane1_ff ^ (lane2_ff >> FIN_SHIFT_A);
            state_in = ST_R2;
         end
         ST_R2: begin
            lane1_in = mul_p;
            mul_op   = lane2_ff ^ (mul_p >> FIN_SHIFT_B);
            state_in = ST_R3;
         end
         ST_R3: begin
            lane2_in = mul_p;
            mul_op   = lane1_ff ^ (mul_p >> FIN_SHIFT_C);
            state_in = ST_R4;
         end
         ST_R4: begin
            lane1_in = mul_p;
            mul_op   = lane2_ff ^ (mul_p >> FIN_SHIFT_D);
            state_in = ST_R5;
         end
         ST_R5: begin
            lane2_in = mul_p;
            state_in = ST_FOUT;
         end
         ST_FOUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.hash_wide   = {lane1_ff, lane2_ff};
               rsp_data_in.hash_narrow = lane1_ff ^ lane2_ff;
               partial_in              = 24'd0;
               slot_in                 = 2'd0;
               nws_in                  = 1'b0;
               inside_in               = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= 32'd0;
         lane1_ff     <= 32'd0;
         lane2_ff     <= 32'd0;
         partial_ff   <= 24'd0;
         slot_ff      <= 2'd0;
         nws_ff       <= 1'b0;
         inside_ff    <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         lane1_ff     <= lane1_in;
         lane2_ff     <= lane2_in;
         partial_ff   <= partial_in;
         slot_ff      <= slot_in;
         nws_ff       <= nws_in;
         inside_ff    <= inside_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a closing item that completes no word goes straight to finalization
   a_last_to_fin: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.last_item &&
      !(req_data.byte_present && eff_slot == 2'd3) |=> state_ff == ST_FSTART)
      else $error("closing item did not start finalization");

   // an ordinary byte is absorbed with the sequencer staying idle
   a_byte_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_data.last_item &&
      !(req_data.byte_present && eff_slot == 2'd3) |=> state_ff == ST_IDLE)
      else $error("non-word byte kept the sequencer busy");

   // lane write-back leaves the packer empty
   a_word_clears_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_W4 |=> slot_ff == 2'd0 && partial_ff == 24'd0)
      else $error("packer not cleared after word mix");

   // a result appears only out of the output state
   a_rsp_from_fout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FOUT)
      else $error("result raised outside output state");

endmodule
